### rtl/core/bht_pkg.sv
// Shared types and codes for the bucketed hash table.
package bht_pkg;

  localparam int KEY_W  = 31;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 3;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_BUCKET   = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISSING  = 3'd4;

  // One request as it moves down the pipe
  typedef struct packed {
    logic             vld;
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
  } bht_item_t;

endpackage

### rtl/core/bht_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/bht_bucket_map.sv
// Two-stage key modulo bucket-count: reciprocal multiply, then narrow fix-up.
module bht_bucket_map
  import bht_pkg::*;
#(
  parameter int NUM_BUCKETS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bht_item_t                      item_i,
  output bht_item_t                      item_o,
  output logic [$clog2(NUM_BUCKETS)-1:0] bkt_o
);

  localparam int L     = $clog2(NUM_BUCKETS);
  localparam int R_W   = L + 1;
  localparam longint unsigned RECIP_L = (64'd1 << KEY_W) / NUM_BUCKETS;
  localparam logic [KEY_W-1:0] RECIP  = RECIP_L[KEY_W-1:0];
  localparam logic [R_W-1:0]   NB     = R_W'(NUM_BUCKETS);

  logic [2*KEY_W-1:0] prod;
  logic [R_W-1:0]     q_lo_r;
  bht_item_t          item_r;
  logic [2*R_W-1:0]   qn;
  logic [R_W-1:0]     rem;
  logic [R_W-1:0]     rem_fix;

  // quotient estimate is exact or one low
  assign prod = {{KEY_W{1'b0}}, item_i.key} * {{KEY_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else begin
      item_r.vld <= item_i.vld;
    end
    item_r.req <= item_i.req;
    item_r.key <= item_i.key;
    q_lo_r     <= prod[KEY_W+L:KEY_W];
  end

  // remainder lies below 2*NUM_BUCKETS, so low bits suffice
  assign qn      = {{R_W{1'b0}}, q_lo_r} * {{R_W{1'b0}}, NB};
  assign rem     = item_r.key[R_W-1:0] - qn[R_W-1:0];
  assign rem_fix = (rem >= NB) ? (rem - NB) : rem;

  assign item_o = item_r;
  assign bkt_o  = rem_fix[L-1:0];

endmodule

### rtl/core/bht_lookup.sv
// Match/update stage: bucket row compare, overflow area, status register.
module bht_lookup
  import bht_pkg::*;
#(
  parameter int NUM_BUCKETS    = 8,
  parameter int BUCKET_SLOTS   = 2,
  parameter int OVERFLOW_SLOTS = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bht_item_t                        item_i,
  input  logic [$clog2(NUM_BUCKETS)-1:0]   bkt_i,
  input  logic [BUCKET_SLOTS*(KEY_W+1)-1:0] rd_row_i,
  output logic                             wr_en_o,
  output logic [$clog2(NUM_BUCKETS)-1:0]   wr_addr_o,
  output logic [BUCKET_SLOTS*(KEY_W+1)-1:0] wr_row_o,
  output logic                             out_strobe_o,
  output logic [STAT_W-1:0]                out_status_o
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam int KS_W  = BUCKET_SLOTS * KEY_W;
  localparam int ROW_W = BUCKET_SLOTS * (KEY_W + 1);

  bht_item_t                                item_r;
  logic [IDX_W-1:0]                         bkt_r;
  logic                                     fwd_vld_r;
  logic [IDX_W-1:0]                         fwd_bkt_r;
  logic [ROW_W-1:0]                         fwd_row_r;
  logic [OVERFLOW_SLOTS-1:0][KEY_W-1:0]     ovf_keys_r;
  logic [OVERFLOW_SLOTS-1:0][KEY_W-1:0]     ovf_keys_nxt;
  logic [OVERFLOW_SLOTS-1:0]                ovf_vld_r;
  logic [OVERFLOW_SLOTS-1:0]                ovf_vld_nxt;
  logic                                     out_strobe_r;
  logic [STAT_W-1:0]                        out_status_r;
  logic [STAT_W-1:0]                        out_status_nxt;

  logic [ROW_W-1:0]                         row;
  logic [BUCKET_SLOTS-1:0][KEY_W-1:0]       row_keys;
  logic [BUCKET_SLOTS-1:0]                  row_vld;
  logic [BUCKET_SLOTS-1:0][KEY_W-1:0]       new_keys;
  logic [BUCKET_SLOTS-1:0]                  new_vld;
  logic [BUCKET_SLOTS-1:0]                  match_b;
  logic [BUCKET_SLOTS-1:0]                  hit_b;
  logic [BUCKET_SLOTS-1:0]                  free_b;
  logic [BUCKET_SLOTS-1:0]                  ins_b;
  logic [OVERFLOW_SLOTS-1:0]                match_o;
  logic [OVERFLOW_SLOTS-1:0]                hit_o;
  logic [OVERFLOW_SLOTS-1:0]                free_o;
  logic [OVERFLOW_SLOTS-1:0]                ins_o;
  logic                                     wr_en;

  // previous beat's row write has not reached the RAM read yet
  assign row      = (fwd_vld_r && fwd_bkt_r == bkt_r) ? fwd_row_r : rd_row_i;
  assign row_keys = row[KS_W-1:0];
  assign row_vld  = row[ROW_W-1:KS_W];

  always_comb begin
    for (int i = 0; i < BUCKET_SLOTS; i++) begin
      match_b[i] = row_vld[i] && (row_keys[i] == item_r.key);
    end
    for (int j = 0; j < OVERFLOW_SLOTS; j++) begin
      match_o[j] = ovf_vld_r[j] && (ovf_keys_r[j] == item_r.key);
    end
  end

  // lowest set bit of each mask
  assign free_b = ~row_vld;
  assign free_o = ~ovf_vld_r;
  assign hit_b  = match_b & (~match_b + BUCKET_SLOTS'(1));
  assign ins_b  = free_b & (~free_b + BUCKET_SLOTS'(1));
  assign hit_o  = match_o & (~match_o + OVERFLOW_SLOTS'(1));
  assign ins_o  = free_o & (~free_o + OVERFLOW_SLOTS'(1));

  always_comb begin
    new_keys       = row_keys;
    new_vld        = row_vld;
    ovf_keys_nxt   = ovf_keys_r;
    ovf_vld_nxt    = ovf_vld_r;
    wr_en          = 1'b0;
    out_status_nxt = ST_MISSING;
    unique case (item_r.req)
      REQ_INSERT: begin
        if (|free_b) begin
          wr_en   = item_r.vld;
          new_vld = row_vld | ins_b;
          for (int i = 0; i < BUCKET_SLOTS; i++) begin
            if (ins_b[i]) begin
              new_keys[i] = item_r.key;
            end
          end
          out_status_nxt = ST_BUCKET;
        end else if (|free_o) begin
          if (item_r.vld) begin
            ovf_vld_nxt = ovf_vld_r | ins_o;
          end
          for (int j = 0; j < OVERFLOW_SLOTS; j++) begin
            if (ins_o[j]) begin
              ovf_keys_nxt[j] = item_r.key;
            end
          end
          out_status_nxt = ST_OVERFLOW;
        end else begin
          out_status_nxt = ST_FULL;
        end
      end
      REQ_SEARCH: begin
        out_status_nxt = ((|match_b) || (|match_o)) ? ST_FOUND : ST_MISSING;
      end
      REQ_DELETE: begin
        if (|match_b) begin
          wr_en          = item_r.vld;
          new_vld        = row_vld & ~hit_b;
          out_status_nxt = ST_FOUND;
        end else if (|match_o) begin
          if (item_r.vld) begin
            ovf_vld_nxt = ovf_vld_r & ~hit_o;
          end
          out_status_nxt = ST_FOUND;
        end
      end
      default: begin
        out_status_nxt = ST_MISSING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld   <= 1'b0;
      fwd_vld_r    <= 1'b0;
      ovf_vld_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      item_r.vld   <= item_i.vld;
      fwd_vld_r    <= wr_en;
      ovf_vld_r    <= ovf_vld_nxt;
      out_strobe_r <= item_r.vld;
    end
    item_r.req   <= item_i.req;
    item_r.key   <= item_i.key;
    bkt_r        <= bkt_i;
    fwd_bkt_r    <= bkt_r;
    fwd_row_r    <= {new_vld, new_keys};
    ovf_keys_r   <= ovf_keys_nxt;
    out_status_r <= out_status_nxt;
  end

  assign wr_en_o      = wr_en;
  assign wr_addr_o    = bkt_r;
  assign wr_row_o     = {new_vld, new_keys};
  assign out_strobe_o = out_strobe_r;
  assign out_status_o = out_status_r;

  a_strobe_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_r.vld |=> out_strobe_r)
    else $error("result beat missing after a request");

  a_ovf_grows_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ovf_vld_r) <= $countones($past(ovf_vld_r)) + 1)
    else $error("overflow area gained more than one entry in a beat");

  a_ovf_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (item_r.vld && item_r.req == REQ_INSERT && (|free_b)) |=> $stable(ovf_vld_r))
    else $error("overflow used while home bucket had room");

endmodule

### rtl/core/bucketed_hash_table_with_overflow.sv
// Top level of the bucketed hash set with shared overflow area.
//
// Hash set of 31-bit keys, duplicates allowed. A key's home bucket is key
// modulo NUM_BUCKETS; each bucket has BUCKET_SLOTS slots, and keys that do
// not fit spill into a shared overflow area of OVERFLOW_SLOTS slots (insert
// is rejected when both are full). Search and delete look in the home bucket
// first, then in the overflow; a delete removes one copy. A request is taken
// on any clock edge with start high and busy low, one request per cycle with
// no gaps. Its result appears on out_status with out_strobe high for exactly
// one cycle, in request order; the receiver cannot stall, so it must take
// every beat. A request passes through the pipe: input register, reciprocal
// multiply, remainder fix-up with bucket RAM read, match/update stage, status
// register. Bucket rows (keys plus valid bits) sit in one RAM of NUM_BUCKETS
// rows; a row written by the previous beat is forwarded round the RAM. After
// reset busy stays high while a clearing pass writes every row empty.
module bucketed_hash_table_with_overflow
  import bht_pkg::*;
#(
  parameter int NUM_BUCKETS    = 8,
  parameter int BUCKET_SLOTS   = 2,
  parameter int OVERFLOW_SLOTS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [KEY_W-1:0]  in_key,
  output logic              out_strobe,
  output logic [STAT_W-1:0] out_status
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam int ROW_W = BUCKET_SLOTS * (KEY_W + 1);
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(NUM_BUCKETS - 1);

  bht_item_t        in_item_r;
  bht_item_t        map_item;
  logic [IDX_W-1:0] map_bkt;

  // clearing pass
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_cnt_r;

  logic [ROW_W-1:0] rd_row;
  logic             lk_we;
  logic [IDX_W-1:0] lk_addr;
  logic [ROW_W-1:0] lk_row;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;

  assign busy = clr_busy_r;

  // input register: a beat is taken when start meets !busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_item_r.vld <= 1'b0;
      clr_busy_r    <= 1'b1;
      clr_cnt_r     <= '0;
    end else begin
      in_item_r.vld <= start && !clr_busy_r;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == LAST_ROW) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
    in_item_r.req <= in_req_type;
    in_item_r.key <= in_key;
  end

  bht_bucket_map #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (in_item_r),
    .item_o (map_item),
    .bkt_o  (map_bkt)
  );

  // clearing pass owns the write port until it finishes
  assign ram_we    = clr_busy_r || lk_we;
  assign ram_waddr = clr_busy_r ? clr_cnt_r : lk_addr;
  assign ram_wdata = clr_busy_r ? '0 : lk_row;

  bht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (map_bkt),
    .rdata (rd_row)
  );

  bht_lookup #(
    .NUM_BUCKETS    (NUM_BUCKETS),
    .BUCKET_SLOTS   (BUCKET_SLOTS),
    .OVERFLOW_SLOTS (OVERFLOW_SLOTS)
  ) u_lookup (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (map_item),
    .bkt_i        (map_bkt),
    .rd_row_i     (rd_row),
    .wr_en_o      (lk_we),
    .wr_addr_o    (lk_addr),
    .wr_row_o     (lk_row),
    .out_strobe_o (out_strobe),
    .out_status_o (out_status)
  );

  a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("clearing pass restarted without reset");

endmodule
